### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the speech transmit queue block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define STQFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true out of reset.
`define STQFC_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/stqfc_pkg.sv
// ----------------------------------------------------------------------------
// stqfc_pkg
// Types and constants shared by the speech transmit queue block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stqfc_pkg;

  // Default queue depth in bytes
  localparam int unsigned QueueBytesDef = 4096;

  // Line codes
  localparam logic [7:0] NullCode    = 8'h16;
  localparam logic [7:0] NewlineCode = 8'h0A;

  // Number of fixed bytes loaded by a flush request
  localparam int unsigned FlushBytes = 3;

  // Request kinds
  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_READY = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_TICK  = 2'd3
  } func_e;

  // One input request
  typedef struct packed {
    func_e       func;
    logic [7:0]  data_byte;
    logic        car_bit;
    logic        ring_bit;
  } item_t;

  // One result
  typedef struct packed {
    logic        put_ok;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        tx_off;
    logic        start_backoff;
    logic        flush_done;
    logic        alarm;
    logic [12:0] queue_count;
  } result_t;

endpackage

### rtl/speech_tx_queue_flow_control_unit.sv
// ----------------------------------------------------------------------------
// speech_tx_queue_flow_control_unit
// Transmit feeder for a speech synthesizer line: byte queue, null flush,
// half-full stop with backoff, and FIFO-empty alarm.
//
//   channel   dir  tdata (low bit up)                          tuser
//   s_axis    in   data_byte, car_bit, ring_bit, pad (16)      func (2)
//   m_axis    out  put_ok, send_valid, send_byte, tx_off,      -
//                  start_backoff, flush_done, alarm,
//                  queue_count, pad (32)
//
// One request per cycle sustained while m_axis does not stall; an accepted
// request passes the input register, then the result register, from which
// the result is offered until it is taken.
// The single queue memory port pair sets the rate: one write and one
// read-ahead per cycle, with a bypass for a byte read right after it is put.
// Reset clears pointers, count and flags at once; no clearing pass.
// A stall on m_axis holds the result register and backs up into s_axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module speech_tx_queue_flow_control_unit #(
  parameter int unsigned QueueBytes = stqfc_pkg::QueueBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // data_byte[7:0], car_bit[8], ring_bit[9]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // put_ok[0], send_valid[1], send_byte[9:2],
                                     // tx_off[10], start_backoff[11],
                                     // flush_done[12], alarm[13],
                                     // queue_count[26:14]
);

  logic               in_valid_q;
  stqfc_pkg::item_t   in_item_q;
  stqfc_pkg::item_t   in_item;
  logic               out_valid_q;
  stqfc_pkg::result_t out_res_q;
  stqfc_pkg::result_t res;
  logic               proc_fire;
  logic               s_fire;

  assign proc_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Unpack the request
  always_comb begin
    in_item.func      = stqfc_pkg::func_e'(s_axis_tuser);
    in_item.data_byte = s_axis_tdata[7:0];
    in_item.car_bit   = s_axis_tdata[8];
    in_item.ring_bit  = s_axis_tdata[9];
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q <= in_item;
    end
  end

  stqfc_ctrl #(
    .QueueBytes (QueueBytes)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc_fire),
    .item_i (in_item_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_res_q <= res;
    end
  end

  // Pack the result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.queue_count, out_res_q.alarm,
                          out_res_q.flush_done, out_res_q.start_backoff,
                          out_res_q.tx_off, out_res_q.send_byte,
                          out_res_q.send_valid, out_res_q.put_ok};

endmodule

### rtl/stqfc_ram.sv
// ----------------------------------------------------------------------------
// stqfc_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stqfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/stqfc_ctrl.sv
// ----------------------------------------------------------------------------
// stqfc_ctrl
// Queue state and per-request decision logic: ring pointers, byte count,
// flush and backoff flags, and the queue memory with its read bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stqfc_ctrl #(
  parameter int unsigned QueueBytes = stqfc_pkg::QueueBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  stqfc_pkg::item_t   item_i,
  output stqfc_pkg::result_t res_o
);

  localparam int unsigned PtrW = $clog2(QueueBytes);
  localparam int unsigned CntW = $clog2(QueueBytes + 1);

  logic [PtrW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic            act_q, act_d;
  logic            armed_q, armed_d;
  logic            watch_q, watch_d;
  logic [stqfc_pkg::FlushBytes-1:0] ovr_q, ovr_d;

  logic            we;
  logic [7:0]      ram_rdata;
  logic            byp_q;
  logic [7:0]      byp_data_q;
  logic [7:0]      head_byte;
  logic            full;
  logic            half;
  logic [1:0]      rp_low;
  logic            rp_fixed;

  stqfc_pkg::result_t res;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QueueBytes - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  // Queue memory: write at the tail, read ahead at the next head
  stqfc_ram #(
    .Width (8),
    .Depth (QueueBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (item_i.data_byte),
    .raddr_i (rp_d),
    .rdata_o (ram_rdata)
  );

  // Forward a byte written to the address being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we && (wp_q == rp_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= item_i.data_byte;
  end

  // Head byte: fixed flush bytes override the memory until overwritten
  assign rp_low   = rp_q[1:0];
  assign rp_fixed = (rp_q < PtrW'(stqfc_pkg::FlushBytes)) && ovr_q[rp_low];

  always_comb begin
    if (rp_fixed) begin
      head_byte = (rp_low == 2'd0) ? stqfc_pkg::NewlineCode : stqfc_pkg::NullCode;
    end else if (byp_q) begin
      head_byte = byp_data_q;
    end else begin
      head_byte = ram_rdata;
    end
  end

  assign full = (cnt_q == CntW'(QueueBytes));
  assign half = !item_i.car_bit && item_i.ring_bit;

  // Decide the result and the next state for one request
  always_comb begin
    res     = '0;
    rp_d    = rp_q;
    wp_d    = wp_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    act_d   = act_q;
    armed_d = armed_q;
    watch_d = watch_q;
    ovr_d   = ovr_q;
    we      = 1'b0;
    if (fire_i) begin
      unique case (item_i.func)
        stqfc_pkg::FUNC_PUT: begin
          if (!full) begin
            we         = 1'b1;
            res.put_ok = 1'b1;
            wp_d       = advance(wp_q);
            cnt_d      = cnt_q + 1'b1;
            if (wp_q < PtrW'(stqfc_pkg::FlushBytes)) begin
              ovr_d[wp_q[1:0]] = 1'b0;
            end
          end
        end
        stqfc_pkg::FUNC_READY: begin
          if (half) begin
            res.tx_off        = 1'b1;
            res.start_backoff = !armed_q;
            armed_d           = 1'b1;
          end else begin
            armed_d = 1'b0;
            if (act_q) begin
              if (!item_i.ring_bit) begin
                act_d          = 1'b0;
                res.flush_done = 1'b1;
              end else begin
                res.send_valid = 1'b1;
                res.send_byte  = stqfc_pkg::NullCode;
              end
            end else if (cnt_q == '0) begin
              res.tx_off = 1'b1;
              if (pend_q) begin
                pend_d = 1'b0;
                act_d  = 1'b1;
              end
            end else begin
              res.send_valid = 1'b1;
              res.send_byte  = head_byte;
              rp_d           = advance(rp_q);
              cnt_d          = cnt_q - 1'b1;
              if ((cnt_q == CntW'(1)) && pend_q) begin
                pend_d = 1'b0;
                act_d  = 1'b1;
              end
            end
          end
        end
        stqfc_pkg::FUNC_FLUSH: begin
          rp_d   = '0;
          wp_d   = PtrW'(stqfc_pkg::FlushBytes);
          cnt_d  = CntW'(stqfc_pkg::FlushBytes);
          act_d  = 1'b0;
          pend_d = 1'b1;
          ovr_d  = '1;
        end
        stqfc_pkg::FUNC_TICK: begin
          if (!item_i.ring_bit) begin
            res.alarm = watch_q;
            watch_d   = 1'b0;
          end else begin
            watch_d = 1'b1;
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
    res.queue_count = 13'(cnt_d);
  end

  assign res_o = res;

  // Hold queue and flag state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= '0;
      wp_q    <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      act_q   <= 1'b0;
      armed_q <= 1'b0;
      watch_q <= 1'b0;
      ovr_q   <= '0;
    end else begin
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      act_q   <= act_d;
      armed_q <= armed_d;
      watch_q <= watch_d;
      ovr_q   <= ovr_d;
    end
  end

  // Checks
  `STQFC_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CntW'(QueueBytes), "byte count over depth")
  `STQFC_NEVER(a_flush_excl, clk_i, rst_ni, pend_q && act_q, "flush pending and active")
  `STQFC_ASSERT(a_ptr_match, clk_i, rst_ni, (cnt_q == '0 || cnt_q == CntW'(QueueBytes)) |-> (wp_q == rp_q), "pointers disagree with count")
  `STQFC_ASSERT(a_backoff_arm, clk_i, rst_ni, (fire_i && res.start_backoff) |=> armed_q, "backoff not armed")

endmodule
